@@ rtl/far_pkg.sv @@
// fraction_arith_reduce package: status codes, commands, sequencer states
// no dependencies
package far_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERODEN = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_GCD,
    S_DIV,
    S_OUT
  } state_e;

endpackage

@@ rtl/far_serdiv.sv @@
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameter
module far_serdiv #(
  parameter int W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dvd_i,
  input  logic [W-1:0] dvs_i,
  output logic         busy_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d, rem_q, rem_d, dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quo_d = dvd_i;
      rem_d = '0;
      cnt_d = CW'(W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) dvs_q <= dvs_i;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  busy_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("divider not busy after start");
  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(W))
    else $error("divider count out of range");
  cnt_down_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !start_i) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("divider count did not step");
endmodule

@@ rtl/fraction_arith_reduce.sv @@
// fraction_arith_reduce: add, subtract, multiply or divide two fractions,
// then reduce by the gcd. uses far_pkg and far_serdiv.
//
// input channel: valid_i/stall_o with cmd_i, num_x_i, den_x_i, num_y_i, den_y_i.
// a word is taken when valid_i is high and stall_o low. output channel:
// valid_o/stall_i with res_num_o, res_den_o, whole_o, status_o; the word
// leaves when valid_o is high and stall_i low, and holds while stalled.
// one word is in work at a time; stall_o stays high until the result left.
// bad input (zero denominator, division by zero fraction) goes from accept
// straight to the output state. otherwise the cross products are formed
// with a shift-add multiplier, one bit per cycle, and the terms are then
// combined; the gcd runs as repeated 64-bit remainders through one
// bit-serial divider (one remainder per euclid step, up to about 46 steps
// at the default width), then two more divisions give the quotients.
// reset clears the sequencer, the output valid flag and the divider start flag; no clearing pass.
module fraction_arith_reduce
  import far_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [15:0] num_x_i,
  input  logic signed [15:0] den_x_i,
  input  logic signed [15:0] num_y_i,
  input  logic signed [15:0] den_y_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [32:0] res_num_o,
  output logic [31:0]        res_den_o,
  output logic               whole_o,
  output logic [1:0]         status_o
);
  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;        // product magnitude bits
  localparam int MCW = $clog2(PW + 1);

  state_e st_q, st_d;

  // sign-magnitude operands after moving denominator signs
  logic [OW-1:0] ma, mb, mc, md;     // |a|,|b|,|c|,|d| as OW bit magnitudes
  logic          sa, sc;             // numerator signs after normalize
  logic signed [OW-1:0] oa, ob, oc, od;

  // shift-add multiplier: three products at once, one multiplier bit per cycle
  logic [PW-1:0]  m1a_q, m1a_d, m2a_q, m2a_d; // multiplicand (shifts left)
  logic [OW-1:0]  m1b_q, m1b_d, m2b_q, m2b_d; // multiplier (shifts right)
  logic [PW-1:0]  p1_q, p1_d, p2_q, p2_d;     // |first term|, |second term|
  logic [PW-1:0]  pf_q, pf_d;                 // denominator product
  logic [PW-1:0]  mfa_q, mfa_d;
  logic [OW-1:0]  mfb_q, mfb_d;
  logic           s1_q, s1_d, s2_q, s2_d;     // term signs
  logic [MCW-1:0] mc_q, mc_d;
  cmd_e           cmd_q, cmd_d;

  // euclid registers
  logic [63:0] ue_q, ue_d, uf_q, uf_d, gp_q, gp_d, gq_q, gq_d;
  logic        neg_q, neg_d;
  logic [1:0]  ph_q, ph_d;           // 0 gcd, 1 numerator quotient, 2 denominator

  // output register
  logic        ov_q, ov_d;
  logic [32:0] on_q, on_d;
  logic [31:0] od_q, od_d;
  logic        ow_q, ow_d;
  status_e     os_q, os_d;

  logic        dv_start, dv_busy, dv_started_q, dv_started_d;
  logic [63:0] dv_dvd, dv_dvs, dv_quo, dv_rem;

  logic        bad_den, bad_div;
  logic [PW:0] esum;                 // signed sum magnitude with carry
  logic [63:0] e_mag;
  logic        e_neg;

  // operands come from the low OW bits of each field, zero filled above 16
  assign oa = OW'($unsigned(num_x_i));
  assign ob = OW'($unsigned(den_x_i));
  assign oc = OW'($unsigned(num_y_i));
  assign od = OW'($unsigned(den_y_i));

  // magnitudes; the most negative value maps to 2^(OW-1) correctly unsigned
  assign ma = oa[OW-1] ? OW'(-oa) : OW'(oa);
  assign mb = ob[OW-1] ? OW'(-ob) : OW'(ob);
  assign mc = oc[OW-1] ? OW'(-oc) : OW'(oc);
  assign md = od[OW-1] ? OW'(-od) : OW'(od);
  assign sa = oa[OW-1] ^ ob[OW-1];
  assign sc = oc[OW-1] ^ od[OW-1];

  assign bad_den = (ob == '0) || (od == '0);
  assign bad_div = (cmd_e'(cmd_i) == CMD_DIV) && (oc == '0);

  far_serdiv #(.W(64)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .dvd_i   (dv_dvd),
    .dvs_i   (dv_dvs),
    .busy_o  (dv_busy),
    .quo_o   (dv_quo),
    .rem_o   (dv_rem)
  );

  // combine the two terms into signed e; for mul/div only term one counts
  always_comb begin
    esum  = '0;
    e_neg = 1'b0;
    if (cmd_q == CMD_MUL || cmd_q == CMD_DIV) begin
      esum  = {1'b0, p1_q};
      e_neg = s1_q;
    end else begin
      if (s1_q == s2_q) begin
        esum  = {1'b0, p1_q} + {1'b0, p2_q};
        e_neg = s1_q;
      end else if (p1_q >= p2_q) begin
        esum  = {1'b0, p1_q} - {1'b0, p2_q};
        e_neg = s1_q;
      end else begin
        esum  = {1'b0, p2_q} - {1'b0, p1_q};
        e_neg = s2_q;
      end
    end
    e_mag = 64'(esum);
    if (e_mag == '0) e_neg = 1'b0;
  end

  always_comb begin
    st_d  = st_q;
    m1a_d = m1a_q; m1b_d = m1b_q; m2a_d = m2a_q; m2b_d = m2b_q;
    mfa_d = mfa_q; mfb_d = mfb_q;
    p1_d  = p1_q;  p2_d  = p2_q;  pf_d  = pf_q;
    s1_d  = s1_q;  s2_d  = s2_q;  mc_d  = mc_q;  cmd_d = cmd_q;
    ue_d  = ue_q;  uf_d  = uf_q;  gp_d  = gp_q;  gq_d  = gq_q;
    neg_d = neg_q; ph_d  = ph_q;
    ov_d  = ov_q;  on_d  = on_q;  od_d  = od_q;  ow_d  = ow_q; os_d = os_q;
    dv_start = 1'b0;
    dv_dvd   = gp_q;
    dv_dvs   = gq_q;
    dv_started_d = dv_started_q;
    // no new word while one is in work or a result still waits
    stall_o  = (st_q != S_IDLE) || ov_q;

    if (ov_q && !stall_i) ov_d = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (valid_i && !ov_q) begin
          cmd_d = cmd_e'(cmd_i);
          if (bad_den || bad_div) begin
            on_d = '0; od_d = '0; ow_d = 1'b0;
            os_d = bad_den ? ST_ZERODEN : ST_DIVZERO;
            st_d = S_OUT;
          end else begin
            // term one: a*d (or a*c for mul); term two: c*b
            m1a_d = PW'(ma);
            m1b_d = (cmd_e'(cmd_i) == CMD_MUL) ? mc : md;
            s1_d  = (cmd_e'(cmd_i) == CMD_MUL) ? (sa ^ sc) : sa;
            m2a_d = PW'(mc);
            m2b_d = mb;
            s2_d  = (cmd_e'(cmd_i) == CMD_SUB) ? ~sc : sc;
            // denominator b*d, or b*c for div (sign of c moves to e)
            mfa_d = PW'(mb);
            mfb_d = (cmd_e'(cmd_i) == CMD_DIV) ? mc : md;
            if (cmd_e'(cmd_i) == CMD_DIV) s1_d = sa ^ sc;
            p1_d = '0; p2_d = '0; pf_d = '0;
            mc_d = MCW'(OW);
            st_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mc_q != '0) begin
          if (m1b_q[0]) p1_d = p1_q + m1a_q;
          if (m2b_q[0]) p2_d = p2_q + m2a_q;
          if (mfb_q[0]) pf_d = pf_q + mfa_q;
          m1a_d = {m1a_q[PW-2:0], 1'b0};
          m2a_d = {m2a_q[PW-2:0], 1'b0};
          mfa_d = {mfa_q[PW-2:0], 1'b0};
          m1b_d = m1b_q >> 1;
          m2b_d = m2b_q >> 1;
          mfb_d = mfb_q >> 1;
          mc_d  = mc_q - 1'b1;
        end else begin
          ue_d  = e_mag;
          neg_d = e_neg;
          uf_d  = 64'(pf_q);
          gp_d  = e_mag;
          gq_d  = 64'(pf_q);
          ph_d  = 2'd0;
          dv_started_d = 1'b0;
          st_d  = S_GCD;
        end
      end
      S_GCD: begin
        // gp/gq walk euclid; each remainder comes from the serial divider
        if (!dv_started_q) begin
          if (gq_q == '0) begin
            gq_d = gp_q;     // gcd found, keep it as divisor
            gp_d = ue_q;
            ph_d = 2'd1;
            st_d = S_DIV;
          end else begin
            dv_start     = 1'b1;
            dv_started_d = 1'b1;
          end
        end else if (!dv_busy) begin
          gp_d = gq_q;
          gq_d = dv_rem;
          dv_started_d = 1'b0;
        end
      end
      S_DIV: begin
        dv_dvd = (ph_q == 2'd1) ? ue_q : uf_q;
        if (!dv_started_q) begin
          dv_start     = 1'b1;
          dv_started_d = 1'b1;
        end else if (!dv_busy) begin
          dv_started_d = 1'b0;
          if (ph_q == 2'd1) begin
            on_d = neg_q ? 33'(-dv_quo) : 33'(dv_quo);
            ph_d = 2'd2;
          end else begin
            od_d = 32'(dv_quo);
            ow_d = (dv_quo == 64'd1);
            os_d = ST_OK;
            st_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!ov_q || !stall_i) begin
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    // hold the output word until it left before raising a new one
    if (st_q == S_OUT && ov_q && stall_i) st_d = S_OUT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      dv_started_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      dv_started_q <= dv_started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m1a_q <= m1a_d; m1b_q <= m1b_d; m2a_q <= m2a_d; m2b_q <= m2b_d;
    mfa_q <= mfa_d; mfb_q <= mfb_d;
    p1_q  <= p1_d;  p2_q  <= p2_d;  pf_q  <= pf_d;
    s1_q  <= s1_d;  s2_q  <= s2_d;  mc_q  <= mc_d;  cmd_q <= cmd_d;
    ue_q  <= ue_d;  uf_q  <= uf_d;  gp_q  <= gp_d;  gq_q  <= gq_d;
    neg_q <= neg_d; ph_q  <= ph_d;
    on_q  <= on_d;  od_q  <= od_d;  ow_q  <= ow_d;  os_q  <= os_d;
  end

  assign valid_o   = ov_q;
  assign res_num_o = on_q;
  assign res_den_o = od_q;
  assign whole_o   = ow_q;
  assign status_o  = os_q;

  busy_stall_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> stall_o)
    else $error("input taken while a word is in work");
  ok_den_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_OK) |-> (res_den_o != '0))
    else $error("ok result with zero denominator");
  err_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (res_num_o == '0 && !whole_o))
    else $error("error result carries data");
  start_gcd_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> (st_q == S_GCD || st_q == S_DIV))
    else $error("divider started outside gcd or quotient phase");
endmodule
